// File: hw/rtl/b2da_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_pkg: shared definitions for the binary to decimal ASCII core
// Widths, character codes and the sequencer state type.
// ----------------------------------------------------------------------------
package b2da_pkg;

  localparam int VALUE_W    = 63;
  localparam int MAX_DIGITS = 19;
  localparam int DIGIT_W    = 4;
  localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
  localparam int CHAR_W     = 8;
  localparam int BIT_CNT_W  = $clog2(VALUE_W + 1);
  localparam int DIG_CNT_W  = $clog2(MAX_DIGITS + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT,
    ST_NEWLINE
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/binary_to_decimal_ascii_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core: decimal ASCII rendering of binary values
// Serial shift-add-3 conversion followed by one character per cycle when not stalled.
// ----------------------------------------------------------------------------
// Each request carries a 63-bit unsigned value; the core answers with its
// decimal digits as ASCII, most significant first and without leading zeros
// (zero gives "0"), followed by a newline flagged with out_last. One request
// is handled at a time: after the accept, the bit-serial shift-add-3
// converter takes one input bit per cycle; then the core steps through the
// digit register one digit at a time, dropping leading zeros until it finds
// the first digit to print, and emits each remaining digit as a character
// while the output side accepts it. A newline follows. in_ready is high only
// while the core is idle; the last character may still sit in the output
// register.
module binary_to_decimal_ascii_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [b2da_pkg::VALUE_W-1:0]  in_value,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [b2da_pkg::CHAR_W-1:0]        out_character,
  output logic                               out_last
);

  localparam int DW = b2da_pkg::DIGIT_W;

  b2da_pkg::state_t state_r, state_nxt;

  logic [b2da_pkg::VALUE_W-1:0]   bin_r, bin_nxt;
  logic [b2da_pkg::BCD_W-1:0]     bcd_r, bcd_nxt;
  logic [b2da_pkg::BCD_W-1:0]     bcd_adj;
  logic [b2da_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [b2da_pkg::DIG_CNT_W-1:0] dig_cnt_r, dig_cnt_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [b2da_pkg::CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                           out_last_r, out_last_nxt;

  logic              in_fire;
  logic              slot_free;
  logic [DW-1:0]     top_digit;

  assign in_ready      = (state_r == b2da_pkg::ST_IDLE);
  assign in_fire       = in_valid && in_ready;
  assign slot_free     = !out_valid_r || out_ready;
  assign top_digit     = bcd_r[b2da_pkg::BCD_W-1 -: DW];
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // Every BCD digit of 5 or more gets 3 added before the shift, so the
  // doubling carries correctly into the next decimal place.
  always_comb begin
    for (int i = 0; i < b2da_pkg::MAX_DIGITS; i++) begin
      if (bcd_r[i*DW +: DW] >= DW'(5)) begin
        bcd_adj[i*DW +: DW] = bcd_r[i*DW +: DW] + DW'(3);
      end else begin
        bcd_adj[i*DW +: DW] = bcd_r[i*DW +: DW];
      end
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      b2da_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = b2da_pkg::ST_CONV;
      end
      b2da_pkg::ST_CONV: begin
        if (bit_cnt_r == b2da_pkg::BIT_CNT_W'(1)) state_nxt = b2da_pkg::ST_SKIP;
      end
      b2da_pkg::ST_SKIP: begin
        if (top_digit != '0 || dig_cnt_r == b2da_pkg::DIG_CNT_W'(1)) begin
          state_nxt = b2da_pkg::ST_EMIT;
        end
      end
      b2da_pkg::ST_EMIT: begin
        if (slot_free && dig_cnt_r == b2da_pkg::DIG_CNT_W'(1)) begin
          state_nxt = b2da_pkg::ST_NEWLINE;
        end
      end
      b2da_pkg::ST_NEWLINE: begin
        if (slot_free) state_nxt = b2da_pkg::ST_IDLE;
      end
      default: state_nxt = b2da_pkg::ST_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      b2da_pkg::ST_IDLE: begin
        if (in_fire) begin
          bin_nxt     = in_value;
          bcd_nxt     = '0;
          bit_cnt_nxt = b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_W);
          dig_cnt_nxt = b2da_pkg::DIG_CNT_W'(b2da_pkg::MAX_DIGITS);
        end
      end
      b2da_pkg::ST_CONV: begin
        // Carries out of the top digit are dropped, which keeps the value
        // modulo the register's decimal range.
        bcd_nxt     = {bcd_adj[b2da_pkg::BCD_W-2:0], bin_r[b2da_pkg::VALUE_W-1]};
        bin_nxt     = {bin_r[b2da_pkg::VALUE_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - b2da_pkg::BIT_CNT_W'(1);
      end
      b2da_pkg::ST_SKIP: begin
        if (top_digit == '0 && dig_cnt_r != b2da_pkg::DIG_CNT_W'(1)) begin
          bcd_nxt     = bcd_r << DW;
          dig_cnt_nxt = dig_cnt_r - b2da_pkg::DIG_CNT_W'(1);
        end
      end
      b2da_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = b2da_pkg::CHAR_ZERO + b2da_pkg::CHAR_W'(top_digit);
          out_last_nxt  = 1'b0;
          bcd_nxt       = bcd_r << DW;
          dig_cnt_nxt   = dig_cnt_r - b2da_pkg::DIG_CNT_W'(1);
        end
      end
      b2da_pkg::ST_NEWLINE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = b2da_pkg::CHAR_NEWLINE;
          out_last_nxt  = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= b2da_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire
